@@ sv/fjd_pkg.sv @@
// Shared types and constants for the FIFO job dispatcher.
// No dependencies; used by fjd_ctrl, fjd_datapath and the top level.
`timescale 1ns / 1ps

package fjd_pkg;

    // Field widths
    localparam int ID_W    = 16;
    localparam int BURST_W = 16;
    localparam int TICK_W  = 32;
    localparam int CAP_W   = 4;

    // Stream payload widths
    localparam int IN_DATA_W  = ID_W + BURST_W;
    localparam int OUT_DATA_W = ID_W + 2 * TICK_W;
    localparam int KIND_W     = 2;

    // Default queue depths
    localparam int READY_DEPTH_DEF = 16;
    localparam int RUN_DEPTH_DEF   = 8;

    // Capacity register after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd1;

    // Request kinds carried on the input tuser
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SUBMIT = 1'b1;

    // Result kinds carried on the output tuser
    typedef enum logic [KIND_W-1:0] {
        EV_FINISH = 2'd0,
        EV_START  = 2'd1,
        EV_REJECT = 2'd2
    } fjd_event_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FINISH,
        ST_REPL,
        ST_WAIT,
        ST_CAP,
        ST_REJECT
    } fjd_state_t;

    // Queue entries
    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [ID_W-1:0]    id;
    } fjd_ready_entry_t;

    typedef struct packed {
        logic [TICK_W-1:0]  start;
        logic [BURST_W-1:0] burst;
        logic [ID_W-1:0]    id;
    } fjd_run_entry_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic take;    // request accepted this cycle
        logic finish;  // pop running head, emit finish
        logic start;   // move ready head to running tail, emit start
        logic reject;  // emit reject for latched job
        logic last;    // tlast for the result emitted this cycle
    } fjd_ctrl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic run_nonempty;
        logic run_done;       // running head has used up its burst
        logic ready_nonempty;
        logic ready_full;
        logic cap_room;       // a capacity start is possible now
        logic repl_cap;       // a capacity start follows a replacement start
        logic out_free;       // output register can load this cycle
    } fjd_status_t;

endpackage

@@ sv/fifo_job_dispatcher_top.sv @@
// Top level of the FIFO job dispatcher: controller plus datapath.
// Depends on fjd_pkg, fjd_ctrl and fjd_datapath.
`timescale 1ns / 1ps

// FIFO job dispatcher
// Input stream: s_axis_tuser selects the request (0 = tick, 1 = submit);
// s_axis_tdata carries job_id and burst_len for a submit.
// Output stream: one result per beat (finished, started, rejected);
// m_axis_tlast marks the final result of a request. A tick gives 0 to 3
// results, a submit gives none, or one reject when the ready queue is full.
// cfg_wr_en/cfg_wr_data load the running capacity (reset value 1); write it
// only while the block is idle.
// Timing: a submit needs only the idle state. A rejected submit then passes
// through ST_REJECT, which loads the reject into the output register once it
// is free; the next request waits for the return to idle. A tick holds the
// input through its accepting state, ST_CHECK for the running head read from
// its queue memory, one state per result (ST_CAP when there is none) and ST_WAIT
// before a capacity start that follows a replacement start, as the ready head read is registered.
// Reset clears queue pointers, counts, tick clock and output valid; queue
// memories are not cleared. When the receiver stalls, the output register
// holds its result; a new request is still taken in the idle state, but the
// next result waits for the register to drain.

module fifo_job_dispatcher_top #(
    parameter int READY_DEPTH = fjd_pkg::READY_DEPTH_DEF,
    parameter int RUN_DEPTH   = fjd_pkg::RUN_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [fjd_pkg::CAP_W-1:0]       cfg_wr_data,   // running_capacity
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fjd_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // job_id, burst_len
    input  logic                            s_axis_tuser,  // cmd
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fjd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // event_job, start_tick, end_tick
    output logic [fjd_pkg::KIND_W-1:0]      m_axis_tuser,  // event_kind
    output logic                            m_axis_tlast
);

    fjd_pkg::fjd_ctrl_t   cmd;
    fjd_pkg::fjd_status_t sts;

    // Controller
    fjd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    fjd_datapath #(
        .READY_DEPTH (READY_DEPTH),
        .RUN_DEPTH   (RUN_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_cmd      (s_axis_tuser),
        .in_data     (s_axis_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_kind    (m_axis_tuser),
        .out_data    (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

    // At most one controller command per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take, cmd.finish, cmd.start, cmd.reject}))
        else $error("more than one controller command in a cycle");

    // Results load only into a free output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish || cmd.start || cmd.reject) |-> sts.out_free)
        else $error("result loaded while output register busy");

    // A reject is the final result of its request
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reject |=> (m_axis_tvalid && m_axis_tlast))
        else $error("reject not presented as last result");

    // A tick is worked through before the next request is taken
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && (s_axis_tuser == fjd_pkg::CMD_TICK)) |=> !s_axis_tready)
        else $error("request taken while a tick is in progress");

    // A start never happens with an empty ready queue
    a_start_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> sts.ready_nonempty)
        else $error("start from empty ready queue");

endmodule

@@ sv/fjd_ctrl.sv @@
// Controller state machine for the FIFO job dispatcher.
// Depends on fjd_pkg; drives fjd_datapath through fjd_ctrl_t commands.
`timescale 1ns / 1ps

module fjd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_ready,
    input  fjd_pkg::fjd_status_t sts,
    output fjd_pkg::fjd_ctrl_t   cmd
);

    fjd_pkg::fjd_state_t state_reg;
    fjd_pkg::fjd_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fjd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            fjd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (in_cmd == fjd_pkg::CMD_SUBMIT)
                    begin
                        if (sts.ready_full)
                        begin
                            state_next = fjd_pkg::ST_REJECT;
                        end
                    end
                    else
                    begin
                        state_next = fjd_pkg::ST_CHECK;
                    end
                end
            end
            fjd_pkg::ST_CHECK:
            begin
                // only the running head is examined
                if (sts.run_nonempty && sts.run_done)
                begin
                    state_next = fjd_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = fjd_pkg::ST_CAP;
                end
            end
            fjd_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    cmd.last   = !sts.ready_nonempty;
                    state_next = sts.ready_nonempty ? fjd_pkg::ST_REPL : fjd_pkg::ST_IDLE;
                end
            end
            fjd_pkg::ST_REPL:
            begin
                if (sts.out_free)
                begin
                    cmd.start  = 1'b1;
                    cmd.last   = !sts.repl_cap;
                    state_next = sts.repl_cap ? fjd_pkg::ST_WAIT : fjd_pkg::ST_IDLE;
                end
            end
            fjd_pkg::ST_WAIT:
            begin
                // ready head moved; let the memory read settle
                state_next = fjd_pkg::ST_CAP;
            end
            fjd_pkg::ST_CAP:
            begin
                if (!sts.cap_room)
                begin
                    state_next = fjd_pkg::ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.start  = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = fjd_pkg::ST_IDLE;
                end
            end
            fjd_pkg::ST_REJECT:
            begin
                if (sts.out_free)
                begin
                    cmd.reject = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = fjd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fjd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/fjd_datapath.sv @@
// Datapath of the FIFO job dispatcher: ready and running queue memories,
// tick clock, capacity register and output register. Depends on fjd_pkg.
`timescale 1ns / 1ps

module fjd_datapath #(
    parameter int READY_DEPTH = fjd_pkg::READY_DEPTH_DEF,
    parameter int RUN_DEPTH   = fjd_pkg::RUN_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [fjd_pkg::CAP_W-1:0]        cfg_wr_data,
    input  logic                             in_cmd,
    input  logic [fjd_pkg::IN_DATA_W-1:0]    in_data,
    input  fjd_pkg::fjd_ctrl_t               cmd,
    output fjd_pkg::fjd_status_t             sts,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [fjd_pkg::KIND_W-1:0]       out_kind,
    output logic [fjd_pkg::OUT_DATA_W-1:0]   out_data,
    output logic                             out_last
);

    localparam int RD_AW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
    localparam int RD_CW = $clog2(READY_DEPTH + 1);
    localparam int RN_AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
    localparam int RN_CW = $clog2(RUN_DEPTH + 1);
    localparam int RD_SW = RD_CW + 1;
    localparam int RN_SW = RN_CW + 1;
    localparam int CMPW  = ((RN_CW > fjd_pkg::CAP_W) ? RN_CW : fjd_pkg::CAP_W) + 1;

    // Queue storage (no reset; only occupied entries are used)
    fjd_pkg::fjd_ready_entry_t ready_mem [READY_DEPTH];
    fjd_pkg::fjd_run_entry_t   run_mem   [RUN_DEPTH];

    fjd_pkg::fjd_ready_entry_t ready_rd_reg;
    fjd_pkg::fjd_run_entry_t   run_rd_reg;

    logic [RD_AW-1:0]              ready_head_reg, ready_head_next;
    logic [RD_CW-1:0]              ready_count_reg, ready_count_next;
    logic [RN_AW-1:0]              run_head_reg, run_head_next;
    logic [RN_CW-1:0]              run_count_reg, run_count_next;
    logic [fjd_pkg::TICK_W-1:0]    clock_reg, clock_next;
    logic [fjd_pkg::CAP_W-1:0]     cap_reg;
    logic [fjd_pkg::ID_W-1:0]      job_id_reg;

    logic                          out_valid_reg;
    fjd_pkg::fjd_event_t           out_kind_reg;
    logic [fjd_pkg::ID_W-1:0]      out_job_reg;
    logic [fjd_pkg::TICK_W-1:0]    out_start_reg;
    logic [fjd_pkg::TICK_W-1:0]    out_end_reg;
    logic                          out_last_reg;

    logic [RD_SW-1:0]              ready_sum;
    logic [RD_AW-1:0]              ready_tail;
    logic [RD_SW-1:0]              ready_head_inc;
    logic [RN_SW-1:0]              run_sum;
    logic [RN_AW-1:0]              run_tail;
    logic [RN_SW-1:0]              run_head_inc;
    logic                          ready_we;
    logic                          tick_take;
    logic [fjd_pkg::TICK_W-1:0]    elapsed;
    logic [CMPW-1:0]               cap_ext;
    logic [CMPW-1:0]               cap_eff;
    logic [CMPW-1:0]               run_cnt_ext;
    logic                          out_load;

    // Tail addresses and head increments with wrap
    always_comb
    begin
        ready_sum      = RD_SW'(ready_head_reg) + RD_SW'(ready_count_reg);
        ready_tail     = (ready_sum >= RD_SW'(READY_DEPTH))
                         ? RD_AW'(ready_sum - RD_SW'(READY_DEPTH)) : RD_AW'(ready_sum);
        ready_head_inc = RD_SW'(ready_head_reg) + RD_SW'(1);
        run_sum        = RN_SW'(run_head_reg) + RN_SW'(run_count_reg);
        run_tail       = (run_sum >= RN_SW'(RUN_DEPTH))
                         ? RN_AW'(run_sum - RN_SW'(RUN_DEPTH)) : RN_AW'(run_sum);
        run_head_inc   = RN_SW'(run_head_reg) + RN_SW'(1);
    end

    assign ready_we  = cmd.take && (in_cmd == fjd_pkg::CMD_SUBMIT) && !sts.ready_full;
    assign tick_take = cmd.take && (in_cmd == fjd_pkg::CMD_TICK);

    // Ready queue memory: write at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (ready_we)
        begin
            ready_mem[ready_tail] <= '{burst: in_data[fjd_pkg::IN_DATA_W-1:fjd_pkg::ID_W],
                                       id:    in_data[fjd_pkg::ID_W-1:0]};
        end
        ready_rd_reg <= ready_mem[ready_head_reg];
    end

    // Running queue memory: write at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            run_mem[run_tail] <= '{start: clock_reg,
                                   burst: ready_rd_reg.burst,
                                   id:    ready_rd_reg.id};
        end
        run_rd_reg <= run_mem[run_head_reg];
    end

    // Queue pointers, counts and tick clock
    always_comb
    begin
        ready_head_next  = ready_head_reg;
        ready_count_next = ready_count_reg;
        run_head_next    = run_head_reg;
        run_count_next   = run_count_reg;
        clock_next       = clock_reg;
        if (ready_we)
        begin
            ready_count_next = ready_count_reg + RD_CW'(1);
        end
        if (tick_take)
        begin
            clock_next = clock_reg + fjd_pkg::TICK_W'(1);
        end
        if (cmd.finish)
        begin
            run_head_next  = (run_head_inc >= RN_SW'(RUN_DEPTH)) ? '0 : RN_AW'(run_head_inc);
            run_count_next = run_count_reg - RN_CW'(1);
        end
        if (cmd.start)
        begin
            ready_head_next  = (ready_head_inc >= RD_SW'(READY_DEPTH))
                               ? '0 : RD_AW'(ready_head_inc);
            ready_count_next = ready_count_reg - RD_CW'(1);
            run_count_next   = run_count_reg + RN_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_head_reg  <= '0;
            ready_count_reg <= '0;
            run_head_reg    <= '0;
            run_count_reg   <= '0;
            clock_reg       <= '0;
        end
        else
        begin
            ready_head_reg  <= ready_head_next;
            ready_count_reg <= ready_count_next;
            run_head_reg    <= run_head_next;
            run_count_reg   <= run_count_next;
            clock_reg       <= clock_next;
        end
    end

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= fjd_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Latched job id for rejects
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            job_id_reg <= in_data[fjd_pkg::ID_W-1:0];
        end
    end

    // Status: finish compare is a wrap-safe unsigned difference
    always_comb
    begin
        elapsed     = clock_reg - run_rd_reg.start;
        cap_ext     = CMPW'(cap_reg);
        cap_eff     = (cap_ext > CMPW'(RUN_DEPTH)) ? CMPW'(RUN_DEPTH) : cap_ext;
        run_cnt_ext = CMPW'(run_count_reg);

        sts.run_nonempty   = (run_count_reg != '0);
        sts.run_done       = (elapsed >= fjd_pkg::TICK_W'(run_rd_reg.burst));
        sts.ready_nonempty = (ready_count_reg != '0);
        sts.ready_full     = (ready_count_reg == RD_CW'(READY_DEPTH));
        sts.cap_room       = (run_cnt_ext < cap_eff) && sts.ready_nonempty;
        sts.repl_cap       = ((run_cnt_ext + CMPW'(1)) < cap_eff)
                             && (ready_count_reg > RD_CW'(1));
        sts.out_free       = !out_valid_reg || out_ready;
    end

    // Output register
    assign out_load = cmd.finish || cmd.start || cmd.reject;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_last_reg <= cmd.last;
            if (cmd.finish)
            begin
                out_kind_reg  <= fjd_pkg::EV_FINISH;
                out_job_reg   <= run_rd_reg.id;
                out_start_reg <= run_rd_reg.start;
                out_end_reg   <= clock_reg;
            end
            else if (cmd.start)
            begin
                out_kind_reg  <= fjd_pkg::EV_START;
                out_job_reg   <= ready_rd_reg.id;
                out_start_reg <= clock_reg;
                out_end_reg   <= '0;
            end
            else
            begin
                out_kind_reg  <= fjd_pkg::EV_REJECT;
                out_job_reg   <= job_id_reg;
                out_start_reg <= '0;
                out_end_reg   <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_data  = {out_end_reg, out_start_reg, out_job_reg};
    assign out_last  = out_last_reg;

endmodule
